[hw/rtl/opdt_pkg.sv]
// ============================================================================
// opdt_pkg: shared definitions for the one-shot/periodic deadline timer
// Request codes, configuration register indexes and fixed field widths.
// ============================================================================
package opdt_pkg;

    localparam int TICK_BITS_DEF = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 1;
    localparam int REQ_W         = 2;
    localparam int REM_W         = 63;

    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 2'd0,
        REQ_STOP    = 2'd1,
        REQ_CHECK   = 2'd2,
        REQ_TIMEOUT = 2'd3
    } req_t;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 1'b1;

endpackage

[hw/rtl/oneshot_periodic_deadline_timer_core.sv]
// ============================================================================
// oneshot_periodic_deadline_timer_core: deadline timer with period catch-up
// Keeps one deadline (zero means stopped) and serves start, stop, check and
// timeout requests, each of which carries the current tick.
// ============================================================================
// Usage. A request beat is taken on the s_ channel when s_valid and s_ready
// are both high; every request gives exactly one result beat on the m_
// channel. The block serves one request at a time, and s_ready is high only
// while it is idle. Start, stop, a check that finds the timer still running
// and a timeout notice that does not match pass from acceptance through
// ST_EXEC and ST_RESULT to m_valid. A request that finds a repeating timer
// expired runs the restoring divider, which develops one remainder bit per
// cycle, then ST_ADJ and, if needed, ST_FIN; a stalled output adds its wait.
// The result sits in an output register, so a new request is accepted while
// the previous beat still waits for m_ready; the block only holds in its
// final step when that register is still occupied. Configuration is written
// through cfg_wr_en, cfg_index and cfg_wdata; the user must do this only
// whilst the block is idle, which the block does not enforce. Reset stops
// the timer, sets a one-tick interval and one-shot mode; no result is pending.
// ============================================================================
module oneshot_periodic_deadline_timer_core #(
    parameter int TICK_BITS = opdt_pkg::TICK_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [opdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [opdt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [opdt_pkg::REQ_W-1:0]       s_req_type,
    input  logic [TICK_BITS-1:0]             s_now_tick,
    input  logic [TICK_BITS-1:0]             s_expired_tick,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_fired,
    output logic                             m_must_wait,
    output logic [opdt_pkg::REM_W-1:0]       m_remaining_ticks,
    output logic                             m_running,
    output logic                             m_changed
);

    localparam int CNT_W = $clog2(TICK_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_ADJ,
        ST_FIN,
        ST_RESULT
    } state_t;

    state_t                        state_reg, state_next;
    opdt_pkg::req_t                req_reg;
    logic [TICK_BITS-1:0]          now_reg;
    logic [TICK_BITS-1:0]          seen_reg;
    logic [TICK_BITS-1:0]          deadline_reg, deadline_next;
    logic [TICK_BITS-1:0]          iv_reg, iv_next;
    logic                          repeat_reg, repeat_next;
    logic [TICK_BITS-1:0]          dvd_reg, dvd_next;
    logic [TICK_BITS-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          res_fired_reg, res_fired_next;
    logic                          res_wait_reg, res_wait_next;
    logic [opdt_pkg::REM_W-1:0]    res_rem_reg, res_rem_next;
    logic                          res_changed_reg, res_changed_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_fired_reg, m_fired_next;
    logic                          m_wait_reg, m_wait_next;
    logic [opdt_pkg::REM_W-1:0]    m_rem_reg, m_rem_next;
    logic                          m_running_reg, m_running_next;
    logic                          m_changed_reg, m_changed_next;

    logic [TICK_BITS-1:0]          cfg_iv;
    logic [TICK_BITS-1:0]          start_sum;
    logic [TICK_BITS-1:0]          check_diff;
    logic [opdt_pkg::REM_W:0]      check_diff_ext;
    logic [TICK_BITS:0]            trial;
    logic [TICK_BITS+1:0]          trial_sub;
    logic                          recalc;

    assign cfg_iv         = cfg_wdata[TICK_BITS-1:0];
    assign start_sum      = now_reg + iv_reg;
    assign check_diff     = deadline_reg - now_reg;
    assign check_diff_ext = (opdt_pkg::REM_W + 1)'(check_diff);
    assign trial          = {rem_reg, dvd_reg[TICK_BITS-1]};
    assign trial_sub      = {1'b0, trial} - {2'b00, iv_reg};

    always_comb begin
        state_next       = state_reg;
        deadline_next    = deadline_reg;
        iv_next          = iv_reg;
        repeat_next      = repeat_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        res_fired_next   = res_fired_reg;
        res_wait_next    = res_wait_reg;
        res_rem_next     = res_rem_reg;
        res_changed_next = res_changed_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_fired_next     = m_fired_reg;
        m_wait_next      = m_wait_reg;
        m_rem_next       = m_rem_reg;
        m_running_next   = m_running_reg;
        m_changed_next   = m_changed_reg;
        recalc           = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                opdt_pkg::REG_INTERVAL: begin
                    iv_next = (cfg_iv == '0) ? TICK_BITS'(1) : cfg_iv;
                end
                opdt_pkg::REG_REPEAT: begin
                    repeat_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_fired_next   = 1'b0;
                res_wait_next    = 1'b0;
                res_rem_next     = '0;
                res_changed_next = 1'b0;
                unique case (req_reg)
                    opdt_pkg::REQ_START: begin
                        if (deadline_reg == '0) begin
                            deadline_next    = start_sum;
                            res_changed_next = (start_sum != '0);
                        end
                    end
                    opdt_pkg::REQ_STOP: begin
                        if (deadline_reg != '0) begin
                            deadline_next    = '0;
                            res_changed_next = 1'b1;
                        end
                    end
                    opdt_pkg::REQ_CHECK: begin
                        if (deadline_reg == '0) begin
                            res_wait_next = 1'b1;
                        end else if (check_diff[TICK_BITS-1]) begin
                            res_fired_next = 1'b1;
                            recalc         = 1'b1;
                        end else begin
                            res_wait_next = 1'b1;
                            res_rem_next  = check_diff_ext[opdt_pkg::REM_W-1:0];
                        end
                    end
                    opdt_pkg::REQ_TIMEOUT: begin
                        if (deadline_reg != '0 && deadline_reg == seen_reg) begin
                            recalc = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = ST_RESULT;
                if (recalc) begin
                    if (!repeat_reg) begin
                        deadline_next = '0;
                    end else begin
                        dvd_next   = now_reg - deadline_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                dvd_next = {dvd_reg[TICK_BITS-2:0], 1'b0};
                rem_next = trial_sub[TICK_BITS+1] ? trial[TICK_BITS-1:0]
                                                  : trial_sub[TICK_BITS-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TICK_BITS - 1)) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                if (rem_reg == '0) begin
                    deadline_next = now_reg;
                    state_next    = ST_RESULT;
                end else begin
                    rem_next   = iv_reg - rem_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                deadline_next = now_reg + rem_reg;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_fired_next   = res_fired_reg;
                    m_wait_next    = res_wait_reg;
                    m_rem_next     = res_rem_reg;
                    m_running_next = (deadline_reg != '0);
                    m_changed_next = res_changed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            req_reg  <= opdt_pkg::req_t'(s_req_type);
            now_reg  <= s_now_tick;
            seen_reg <= s_expired_tick;
        end
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        res_fired_reg   <= res_fired_next;
        res_wait_reg    <= res_wait_next;
        res_rem_reg     <= res_rem_next;
        res_changed_reg <= res_changed_next;
        m_fired_reg     <= m_fired_next;
        m_wait_reg      <= m_wait_next;
        m_rem_reg       <= m_rem_next;
        m_running_reg   <= m_running_next;
        m_changed_reg   <= m_changed_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            deadline_reg <= '0;
            iv_reg       <= TICK_BITS'(1);
            repeat_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            deadline_reg <= deadline_next;
            iv_reg       <= iv_next;
            repeat_reg   <= repeat_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_fired           = m_fired_reg;
    assign m_must_wait       = m_wait_reg;
    assign m_remaining_ticks = m_rem_reg;
    assign m_running         = m_running_reg;
    assign m_changed         = m_changed_reg;

`ifndef SYNTH
    // The deadline only moves whilst a request is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |=> $stable(deadline_reg))
        else $error("deadline changed while the timer was idle");

    // The partial remainder must stay below the interval throughout division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < iv_reg)
        else $error("divider remainder reached the interval");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_fired_reg |-> !m_wait_reg && m_rem_reg == '0)
        else $error("fired beat also reports waiting or remaining ticks");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_changed_reg |-> !m_fired_reg && !m_wait_reg)
        else $error("changed flag on a beat from a check request");
`endif

endmodule
